@@ rtl/kfht_pkg.sv @@
// Shared types and constants of the keyed frame history table.
package kfht_pkg;

  localparam int FRAME_BITS = 64;
  localparam int SCENE_BITS = 32;
  localparam int KEY_PORT_BITS = 64;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_TOUCH = 2'd1,
    OP_END   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // Status of one entry as it comes out of the compare unit.
  typedef struct packed {
    logic used;
    logic match;
    logic is_free;
  } scan_flags_t;

endpackage

@@ rtl/keyed_frame_history_table_unit.sv @@
// Top level of the keyed frame history table: sequencer, entry RAM and result register.
//
// Both tables share one RAM of 2*TABLE_ENTRIES entries that is scanned one entry per
// cycle through its single registered read port. After reset the block clears the
// whole RAM before it takes the first item. A touch scans the selected table, waits
// in a drain state for the last read and then writes the entry and the result; it
// also waits while the result register still holds a previous result that has not
// been taken. An end frame is a read-modify-write sweep over both tables. A begin
// frame stores the frame number, and clears both tables when the scene id changes.
// Input stall is high whenever the sequencer is busy; a finished result waits in the
// output register without holding up the next item.
module keyed_frame_history_table_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 64,
  parameter int VALUE_BITS    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic                                table_sel_i,
  input  logic [kfht_pkg::FRAME_BITS-1:0]     frame_number_i,
  input  logic [kfht_pkg::SCENE_BITS-1:0]     scene_id_i,
  input  logic [kfht_pkg::KEY_PORT_BITS-1:0]  key_i,
  input  logic [kfht_pkg::DATA_BITS-1:0]      value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kfht_pkg::DATA_BITS-1:0]      current_value_o,
  output logic [kfht_pkg::DATA_BITS-1:0]      previous_value_o,
  output logic                                prior_valid_o,
  output logic                                table_full_o
);
  import kfht_pkg::*;

  localparam int VW        = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
  localparam int DEPTH     = 2 * TABLE_ENTRIES;
  localparam int AW        = $clog2(DEPTH);
  localparam int LS_LSB    = 0;
  localparam int PREV_LSB  = LS_LSB + FRAME_BITS;
  localparam int CUR_LSB   = PREV_LSB + VW;
  localparam int KEY_LSB   = CUR_LSB + VW;
  localparam int PV_BIT    = KEY_LSB + KEY_BITS;
  localparam int USED_BIT  = PV_BIT + 1;
  localparam int WORD_BITS = USED_BIT + 1;

  // Control state
  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [AW-1:0]         end_q, end_d;
  logic                  pend_q, pend_d;
  logic                  hit_q, hit_d;
  logic                  free_q, free_d;
  logic                  out_valid_q, out_valid_d;
  logic [FRAME_BITS-1:0] frame_now_q, frame_now_d;
  logic [SCENE_BITS-1:0] scene_now_q, scene_now_d;

  // Payload
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VW-1:0]         value_q, value_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         hit_idx_q, hit_idx_d;
  logic [AW-1:0]         free_idx_q, free_idx_d;
  logic                  hit_pv_q, hit_pv_d;
  logic [VW-1:0]         hit_prev_q, hit_prev_d;
  logic [DATA_BITS-1:0]  cur_out_q, cur_out_d;
  logic [DATA_BITS-1:0]  prev_out_q, prev_out_d;
  logic                  pv_out_q, pv_out_d;
  logic                  full_out_q, full_out_d;

  // RAM ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;

  // Fields of the entry read last cycle
  logic                  rd_used;
  logic                  rd_pv;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VW-1:0]         rd_cur;
  logic [VW-1:0]         rd_prev;
  logic [FRAME_BITS-1:0] rd_seen;

  scan_flags_t           flags;
  logic                  sw_used;
  logic                  sw_pv;
  logic [VW-1:0]         sw_prev;
  logic [WORD_BITS-1:0]  sweep_word;
  logic [WORD_BITS-1:0]  touch_word;
  logic [VW-1:0]         touch_prev;
  logic                  touch_pv;
  logic                  out_free;

  assign rd_used = ram_rdata[USED_BIT];
  assign rd_pv   = ram_rdata[PV_BIT];
  assign rd_key  = ram_rdata[KEY_LSB +: KEY_BITS];
  assign rd_cur  = ram_rdata[CUR_LSB +: VW];
  assign rd_prev = ram_rdata[PREV_LSB +: VW];
  assign rd_seen = ram_rdata[LS_LSB +: FRAME_BITS];

  kfht_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  kfht_entry_unit #(
    .KEY_BITS (KEY_BITS),
    .VAL_BITS (VW)
  ) u_entry (
    .sweep_mode_i (op_q != OP_TOUCH),
    .used_i       (rd_used),
    .prev_valid_i (rd_pv),
    .entry_key_i  (rd_key),
    .last_seen_i  (rd_seen),
    .current_i    (rd_cur),
    .previous_i   (rd_prev),
    .ref_key_i    (key_q),
    .frame_now_i  (frame_now_q),
    .flags_o      (flags),
    .used_o       (sw_used),
    .prev_valid_o (sw_pv),
    .previous_o   (sw_prev)
  );

  assign sweep_word = {sw_used, sw_pv, rd_key, rd_cur, sw_prev, rd_seen};
  assign touch_pv   = hit_q & hit_pv_q;
  assign touch_prev = touch_pv ? hit_prev_q : value_q;
  assign touch_word = {1'b1, 1'b1, key_q, value_q, touch_prev, frame_now_q};
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    end_d       = end_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    free_d      = free_q;
    out_valid_d = out_valid_q & out_stall_i;
    frame_now_d = frame_now_q;
    scene_now_d = scene_now_q;
    key_d       = key_q;
    value_d     = value_q;
    idx_d       = addr_q;
    hit_idx_d   = hit_idx_q;
    free_idx_d  = free_idx_q;
    hit_pv_d    = hit_pv_q;
    hit_prev_d  = hit_prev_q;
    cur_out_d   = cur_out_q;
    prev_out_d  = prev_out_q;
    pv_out_d    = pv_out_q;
    full_out_d  = full_out_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = sweep_word;
    ram_re      = 1'b0;
    ram_raddr   = addr_q;

    // Data read in the previous cycle: note the first hit and first free entry of a
    // touch, or write back the evicted or promoted entry of an end frame.
    if (pend_q) begin
      if (op_q == OP_TOUCH) begin
        if (flags.match && !hit_q) begin
          hit_d      = 1'b1;
          hit_idx_d  = idx_q;
          hit_pv_d   = rd_pv;
          hit_prev_d = rd_prev;
        end
        if (flags.is_free && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
      end else if (flags.used) begin
        ram_we = 1'b1;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = '0;
        addr_d    = addr_q + 1'b1;
        if (addr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(operation_i);
          key_d   = key_i[KEY_BITS-1:0];
          value_d = value_i[VW-1:0];
          hit_d   = 1'b0;
          free_d  = 1'b0;
          case (op_e'(operation_i))
            OP_BEGIN: begin
              frame_now_d = frame_number_i;
              if (scene_id_i != scene_now_q) begin
                scene_now_d = scene_id_i;
                addr_d      = '0;
                state_d     = ST_CLEAR;
              end
            end
            OP_TOUCH: begin
              addr_d  = table_sel_i ? AW'(TABLE_ENTRIES) : '0;
              end_d   = table_sel_i ? AW'(DEPTH - 1) : AW'(TABLE_ENTRIES - 1);
              state_d = ST_RUN;
            end
            OP_END: begin
              addr_d  = '0;
              end_d   = AW'(DEPTH - 1);
              state_d = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        ram_re = 1'b1;
        pend_d = 1'b1;
        idx_d  = addr_q;
        addr_d = addr_q + 1'b1;
        if (addr_q == end_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = (op_q == OP_TOUCH) ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          cur_out_d   = DATA_BITS'(value_q);
          prev_out_d  = DATA_BITS'(touch_prev);
          pv_out_d    = touch_pv;
          full_out_d  = ~hit_q & ~free_q;
          if (hit_q || free_q) begin
            ram_we    = 1'b1;
            ram_waddr = hit_q ? hit_idx_q : free_idx_q;
            ram_wdata = touch_word;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      op_q        <= OP_BEGIN;
      addr_q      <= '0;
      end_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
      frame_now_q <= '0;
      scene_now_q <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      addr_q      <= addr_d;
      end_q       <= end_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      frame_now_q <= frame_now_d;
      scene_now_q <= scene_now_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    value_q    <= value_d;
    idx_q      <= idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    hit_pv_q   <= hit_pv_d;
    hit_prev_q <= hit_prev_d;
    cur_out_q  <= cur_out_d;
    prev_out_q <= prev_out_d;
    pv_out_q   <= pv_out_d;
    full_out_q <= full_out_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign current_value_o  = cur_out_q;
  assign previous_value_o = prev_out_q;
  assign prior_valid_o    = pv_out_q;
  assign table_full_o     = full_out_q;

  // The sweep writes back one entry while it reads the next; they must never collide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (ram_raddr <= AW'(DEPTH - 1)))
    else $error("RAM read beyond the end of the tables");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |-> (op_q == OP_TOUCH))
    else $error("Result stage entered for an item other than a touch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(prior_valid_o && table_full_o))
    else $error("A full table reported a valid previous value");

endmodule

@@ rtl/kfht_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module kfht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/kfht_entry_unit.sv @@
// Shared compare unit: checks one table entry for a key hit or for the current frame.
module kfht_entry_unit #(
  parameter int KEY_BITS = 64,
  parameter int VAL_BITS = 32
) (
  input  logic                             sweep_mode_i,
  input  logic                             used_i,
  input  logic                             prev_valid_i,
  input  logic [KEY_BITS-1:0]              entry_key_i,
  input  logic [kfht_pkg::FRAME_BITS-1:0]  last_seen_i,
  input  logic [VAL_BITS-1:0]              current_i,
  input  logic [VAL_BITS-1:0]              previous_i,
  input  logic [KEY_BITS-1:0]              ref_key_i,
  input  logic [kfht_pkg::FRAME_BITS-1:0]  frame_now_i,
  output kfht_pkg::scan_flags_t            flags_o,
  output logic                             used_o,
  output logic                             prev_valid_o,
  output logic [VAL_BITS-1:0]              previous_o
);
  import kfht_pkg::*;

  logic [FRAME_BITS-1:0] cmp_a;
  logic [FRAME_BITS-1:0] cmp_b;
  logic                  equal;

  // One equality comparator serves the key search and the end-of-frame check.
  always_comb begin
    if (sweep_mode_i) begin
      cmp_a = last_seen_i;
      cmp_b = frame_now_i;
    end else begin
      cmp_a = FRAME_BITS'(entry_key_i);
      cmp_b = FRAME_BITS'(ref_key_i);
    end
  end

  assign equal = (cmp_a == cmp_b);

  assign flags_o.used    = used_i;
  assign flags_o.match   = used_i & equal;
  assign flags_o.is_free = ~used_i;

  // End of frame: entries seen this frame promote current to previous,
  // all other used entries are evicted.
  always_comb begin
    used_o       = used_i;
    prev_valid_o = prev_valid_i;
    previous_o   = previous_i;
    if (used_i) begin
      if (equal) begin
        prev_valid_o = 1'b1;
        previous_o   = current_i;
      end else begin
        used_o       = 1'b0;
        prev_valid_o = 1'b0;
      end
    end
  end

endmodule

@@ verif/keyed_frame_history_table_unit_test.sv @@
// Self-checking testbench of the keyed frame history table with a built-in history predictor.
module keyed_frame_history_table_unit_test;
  import kfht_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int SLOTS = 2 * TABLE_ENTRIES;
  localparam int ITEM_TARGET = 1800;
  localparam int POOL_KEYS = 32;
  localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 8;
  localparam int WATCHDOG_LIMIT = 16 * TABLE_ENTRIES;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic                     sel;
    logic [FRAME_BITS-1:0]    frame;
    logic [SCENE_BITS-1:0]    scene;
    logic [KEY_PORT_BITS-1:0] key;
    logic [DATA_BITS-1:0]     value;
  } frame_item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] cur;
    logic [DATA_BITS-1:0] prev;
    logic                 prev_ok;
    logic                 full;
  } history_reply_t;

  typedef struct {
    frame_item_t    item;
    bit             typed;
    history_reply_t want;
  } script_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               operation_i = '0;
  logic                     table_sel_i = 1'b0;
  logic [FRAME_BITS-1:0]    frame_number_i = '0;
  logic [SCENE_BITS-1:0]    scene_id_i = '0;
  logic [KEY_PORT_BITS-1:0] key_i = '0;
  logic [DATA_BITS-1:0]     value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [DATA_BITS-1:0]     current_value_o;
  logic [DATA_BITS-1:0]     previous_value_o;
  logic                     prior_valid_o;
  logic                     table_full_o;

  // Predicted contents of both tables; the second table starts at TABLE_ENTRIES.
  bit                       slot_used [SLOTS];
  bit                       slot_prev_ok [SLOTS];
  logic [KEY_PORT_BITS-1:0] slot_key [SLOTS];
  logic [DATA_BITS-1:0]     slot_cur [SLOTS];
  logic [DATA_BITS-1:0]     slot_prev [SLOTS];
  logic [FRAME_BITS-1:0]    slot_seen [SLOTS];
  logic [FRAME_BITS-1:0]    frame_now;
  logic [SCENE_BITS-1:0]    scene_now;

  history_reply_t replies_due [$];
  script_row_t    script [$];
  int             fault_count = 0;
  int             idle_cycles = 0;
  bit             feeding = 1'b0;
  bit             no_idle = 1'b0;

  keyed_frame_history_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BITS(64),
    .VALUE_BITS(32)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operation_i(operation_i),
    .table_sel_i(table_sel_i),
    .frame_number_i(frame_number_i),
    .scene_id_i(scene_id_i),
    .key_i(key_i),
    .value_i(value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .current_value_o(current_value_o),
    .previous_value_o(previous_value_o),
    .prior_valid_o(prior_valid_o),
    .table_full_o(table_full_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_wait();
    if (no_idle || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void history_clear();
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_prev_ok[i] = 1'b0;
      slot_key[i] = '0;
      slot_cur[i] = '0;
      slot_prev[i] = '0;
      slot_seen[i] = '0;
    end
  endfunction

  // Applies one item to the predicted tables; returns 1 when the item yields a result.
  function automatic bit history_apply(input frame_item_t it, output history_reply_t reply);
    int base;
    int hit;
    int spare;
    reply = '0;
    case (it.op)
      OP_BEGIN: begin
        frame_now = it.frame;
        if (scene_now != it.scene) begin
          history_clear();
          scene_now = it.scene;
        end
        return 1'b0;
      end
      OP_END: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_seen[i] != frame_now) begin
            slot_used[i] = 1'b0;
            slot_prev_ok[i] = 1'b0;
          end else if (slot_used[i]) begin
            slot_prev[i] = slot_cur[i];
            slot_prev_ok[i] = 1'b1;
          end
        end
        return 1'b0;
      end
      OP_TOUCH: begin
        base = it.sel ? TABLE_ENTRIES : 0;
        hit = -1;
        spare = -1;
        for (int i = base; i < base + TABLE_ENTRIES; i++) begin
          if (slot_used[i]) begin
            if (hit < 0 && slot_key[i] == it.key) hit = i;
          end else if (spare < 0) begin
            spare = i;
          end
        end
        reply.cur = it.value;
        reply.prev = it.value;
        if (hit >= 0) begin
          if (slot_prev_ok[hit]) begin
            reply.prev = slot_prev[hit];
            reply.prev_ok = 1'b1;
          end else begin
            slot_prev[hit] = it.value;
            slot_prev_ok[hit] = 1'b1;
          end
          slot_cur[hit] = it.value;
          slot_seen[hit] = frame_now;
        end else if (spare >= 0) begin
          slot_used[spare] = 1'b1;
          slot_key[spare] = it.key;
          slot_cur[spare] = it.value;
          slot_prev[spare] = it.value;
          slot_prev_ok[spare] = 1'b1;
          slot_seen[spare] = frame_now;
        end else begin
          reply.full = 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_row(input frame_item_t it, input bit typed,
                                  input history_reply_t want);
    script_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  // Presents one item and returns at the edge where it is transferred.
  task automatic send_item(input frame_item_t it, input bit typed, input history_reply_t want);
    int gap;
    history_reply_t reply;
    gap = pick_wait();
    if (gap > 0) begin
      if (feeding) begin
        in_valid_i <= 1'b0;
        feeding = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    feeding = 1'b1;
    operation_i <= it.op;
    table_sel_i <= it.sel;
    frame_number_i <= it.frame;
    scene_id_i <= it.scene;
    key_i <= it.key;
    value_i <= it.value;
    do @(posedge clk_i); while (in_stall_o);
    if (history_apply(it, reply)) begin
      replies_due.push_back(typed ? want : reply);
    end
  endtask

  // Holds the sender off until every pending result has come out.
  task automatic await_replies();
    if (feeding) begin
      in_valid_i <= 1'b0;
      feeding = 1'b0;
    end
    do @(posedge clk_i); while (replies_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : reply_monitor
    int hold;
    history_reply_t want;
    wait (rst_ni === 1'b1);
    forever begin
      hold = pick_wait();
      out_stall_i <= (hold != 0);
      // A drawn hold-off starts counting once a result is waiting.
      do @(posedge clk_i); while (!out_valid_o);
      if (hold != 0) begin
        repeat (hold - 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
      if (replies_due.size() == 0) begin
        $error("result with no touch pending: current_value %h", current_value_o);
        fault_count++;
      end else begin
        want = replies_due.pop_front();
        if (current_value_o !== want.cur) begin
          $error("current_value: expected %h, got %h", want.cur, current_value_o);
          fault_count++;
        end
        if (previous_value_o !== want.prev) begin
          $error("previous_value: expected %h, got %h", want.prev, previous_value_o);
          fault_count++;
        end
        if (prior_valid_o !== want.prev_ok) begin
          $error("prior_valid: expected %b, got %b", want.prev_ok, prior_valid_o);
          fault_count++;
        end
        if (table_full_o !== want.full) begin
          $error("table_full: expected %b, got %b", want.full, table_full_o);
          fault_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [KEY_PORT_BITS-1:0] key_pool [POOL_KEYS];
    logic [SCENE_BITS-1:0]    scene_pool [4];
    logic [FRAME_BITS-1:0]    frame_pick;
    logic [SCENE_BITS-1:0]    scene_pick;
    logic [KEY_PORT_BITS-1:0] key_pick;
    logic [DATA_BITS-1:0]     value_pick;
    logic [1:0]               op_pick;
    logic                     sel_pick;
    logic                     fill_sel;
    bit                       fill;
    int                       items;
    int                       frames;
    int                       count;
    int                       k;

    history_clear();
    frame_now = '0;
    scene_now = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = rand64();
    scene_pool[0] = '0;
    scene_pool[1] = '1;
    scene_pool[2] = $urandom;
    scene_pool[3] = $urandom;

    // op, table, frame, scene, key, value; typed rows carry their own expectation.
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b1,
            {32'd0, 32'd0, 1'b0, 1'b0});
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'd0, 32'hFFFF_FFFF}, 1'b1,
            {32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0});
    add_row({OP_TOUCH, 1'b1, 64'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678}, 1'b1,
            {32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0});
    add_row({OP_UNUSED, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0);
    add_row({OP_END, 1'b0, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_BEGIN, 1'b0, 64'd1, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'd0, 32'd5}, 1'b1,
            {32'd5, 32'hFFFF_FFFF, 1'b1, 1'b0});
    add_row({OP_TOUCH, 1'b1, 64'd0, 32'd0, 64'd0, 32'd9}, 1'b0, '0);
    add_row({OP_END, 1'b1, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_BEGIN, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
    // The evicted key returns to the lowest free entry as a new key.
    add_row({OP_TOUCH, 1'b1, 64'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5}, 1'b1,
            {32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0, 1'b0});
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'd0, 32'd1}, 1'b0, '0);
    add_row({OP_END, 1'b0, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_BEGIN, 1'b0, 64'd2, 32'hFFFF_FFFF, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'd0, 32'd7}, 1'b1,
            {32'd7, 32'd7, 1'b0, 1'b0});
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'h8000_0000_0000_0000, 32'h8000_0000}, 1'b0, '0);
    add_row({OP_END, 1'b0, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'h8000_0000_0000_0000, 32'd3}, 1'b0, '0);
    add_row({OP_BEGIN, 1'b0, 64'd3, 32'hFFFF_FFFF, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_TOUCH, 1'b0, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
    add_row({OP_BEGIN, 1'b0, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_item(script[i].item, script[i].typed, script[i].want);
    await_replies();

    // Frames of touches from a small key pool, now and then a frame that overfills
    // one table, mixed with unknown operations and frames missing a begin or an end.
    items = 0;
    frames = 0;
    while (items < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 15) != 0) begin
        k = $urandom_range(0, 19);
        if (k < 14) frame_pick = frame_now + 64'd1;
        else if (k < 17) frame_pick = frame_now;
        else frame_pick = rand64();
        scene_pick = ($urandom_range(0, 4) == 0) ? scene_pool[$urandom_range(0, 3)] : scene_now;
        send_item({OP_BEGIN, 1'b0, frame_pick, scene_pick, 64'd0, 32'd0}, 1'b0, '0);
        items++;
      end
      fill = ($urandom_range(0, 14) == 0);
      fill_sel = 1'($urandom_range(0, 1));
      count = fill ? TABLE_ENTRIES + 8 : $urandom_range(1, 24);
      repeat (count) begin
        sel_pick = fill ? fill_sel : logic'($urandom_range(0, 1));
        if (fill || $urandom_range(0, 7) == 0) key_pick = rand64();
        else key_pick = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        k = $urandom_range(0, 15);
        if (k == 0) value_pick = '0;
        else if (k == 1) value_pick = '1;
        else value_pick = $urandom;
        op_pick = ($urandom_range(0, 39) == 0) ? OP_UNUSED : OP_TOUCH;
        frame_pick = rand64();
        scene_pick = $urandom;
        send_item({op_pick, sel_pick, frame_pick, scene_pick, key_pick, value_pick}, 1'b0, '0);
        if (op_pick != OP_UNUSED) items++;
      end
      if ($urandom_range(0, 9) != 0) begin
        send_item({OP_END, 1'b0, 64'd0, 32'd0, 64'd0, 32'd0}, 1'b0, '0);
        items++;
      end
      frames++;
      if (frames % 20 == 0) await_replies();
    end

    await_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
